FILE: src/lpa_pkg.sv
package lpa_pkg;

   // List geometry
   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 4;
   localparam int VAL_W    = 32;
   localparam int KIND_W   = 2;
   localparam int STAT_W   = 3;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ALTER  = 2'd3;

   // Status codes
   localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STAT_W-1:0] ST_REDIRECT = 3'd3;
   localparam logic [STAT_W-1:0] ST_INVALID  = 3'd4;

   // Access to the entry memory
   typedef struct packed {
      logic                    wr_en;
      logic [IDX_W-1:0]        wr_addr;
      logic signed [VAL_W-1:0] wr_data;
      logic                    rd_en;
      logic [IDX_W-1:0]        rd_addr;
   } mem_cmd_type;

endpackage

FILE: src/lpa_req_if.sv
interface lpa_req_if;
   logic                             valid;
   logic                             ready;
   logic [lpa_pkg::KIND_W-1:0]       kind;
   logic [lpa_pkg::POS_W-1:0]        position;
   logic signed [lpa_pkg::VAL_W-1:0] value;

   modport source (output valid, output kind, output position, output value, input ready);
   modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

FILE: src/lpa_rsp_if.sv
interface lpa_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [lpa_pkg::VAL_W-1:0] read_value;
   logic [lpa_pkg::CNT_W-1:0]        item_count;
   logic [lpa_pkg::STAT_W-1:0]       status;

   modport source (output valid, output read_value, output item_count, output status,
                   input ready);
   modport sink   (input valid, input read_value, input item_count, input status,
                   output ready);
endinterface

FILE: src/lpa_mem.sv
module lpa_mem (
   input  logic                             clock,
   input  lpa_pkg::mem_cmd_type             cmd,
   output logic signed [lpa_pkg::VAL_W-1:0] rd_data
);

   logic signed [lpa_pkg::VAL_W-1:0] entry_mem [lpa_pkg::CAPACITY];
   logic signed [lpa_pkg::VAL_W-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         entry_mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= entry_mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/positional_array_list.sv
// Sequence: read, alter, append and refused requests pass from idle through the output state to the result
//   register; insert inside the list first shifts entries up, then writes the new value; remove shifts entries down.
// Throughput: one request at a time; the next is taken once the block is idle again.
//   Each shifted entry is read and then written back through the entry memory port.
// Reset (synchronous, active high) clears the count, the sequencer and the result valid
//   flag; the result payload and the entry memory are not cleared.
module positional_array_list (
   input  logic      clock,
   input  logic      reset,
   lpa_req_if.sink   req_ch,
   lpa_rsp_if.source rsp_ch
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_WR   = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]                         state_ff, state_in;
   logic [lpa_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [lpa_pkg::IDX_W-1:0]          src_ff, src_in;
   logic [lpa_pkg::IDX_W-1:0]          dst_ff, dst_in;
   logic [lpa_pkg::IDX_W-1:0]          stop_ff, stop_in;
   logic signed [lpa_pkg::VAL_W-1:0]   val_ff, val_in;
   logic                               ins_ff, ins_in;
   logic                               rdf_ff, rdf_in;
   logic [lpa_pkg::STAT_W-1:0]         stat_ff, stat_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [lpa_pkg::VAL_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [lpa_pkg::CNT_W-1:0]          rsp_count_ff, rsp_count_in;
   logic [lpa_pkg::STAT_W-1:0]         rsp_stat_ff, rsp_stat_in;

   lpa_pkg::mem_cmd_type               mem_cmd;
   logic signed [lpa_pkg::VAL_W-1:0]   mem_rd_data;

   logic                               req_fire;
   logic [lpa_pkg::CMP_W-1:0]          pos_ext;
   logic [lpa_pkg::CMP_W-1:0]          cnt_ext;
   logic [lpa_pkg::CNT_W-1:0]          cnt_dec;
   logic [lpa_pkg::IDX_W-1:0]          pos_idx;
   logic [lpa_pkg::IDX_W-1:0]          cnt_idx;
   logic [lpa_pkg::IDX_W-1:0]          last_idx;

   lpa_mem u_mem (
      .clock   (clock),
      .cmd     (mem_cmd),
      .rd_data (mem_rd_data)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // Index views of position and count
   assign pos_ext  = lpa_pkg::CMP_W'(req_ch.position);
   assign cnt_ext  = lpa_pkg::CMP_W'(count_ff);
   assign cnt_dec  = count_ff - lpa_pkg::CNT_W'(1);
   assign pos_idx  = pos_ext[lpa_pkg::IDX_W-1:0];
   assign cnt_idx  = cnt_ext[lpa_pkg::IDX_W-1:0];
   assign last_idx = cnt_dec[lpa_pkg::IDX_W-1:0];

   // Sequencer: decode request, shift entries through the memory, post result
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      stop_in      = stop_ff;
      val_in       = val_ff;
      ins_in       = ins_ff;
      rdf_in       = rdf_ff;
      stat_in      = stat_ff;
      mem_cmd      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      rsp_stat_in  = rsp_stat_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               stat_in  = lpa_pkg::ST_DONE;
               rdf_in   = 1'b0;
               val_in   = req_ch.value;
               state_in = S_OUT;
               if (req_ch.kind == lpa_pkg::KIND_INSERT) begin
                  if (count_ff >= lpa_pkg::CNT_W'(lpa_pkg::CAPACITY)) begin
                     stat_in = lpa_pkg::ST_FULL;
                  end else if (pos_ext > lpa_pkg::CMP_W'(lpa_pkg::CAPACITY - 1)) begin
                     stat_in = lpa_pkg::ST_INVALID;
                  end else if (pos_ext >= cnt_ext) begin
                     // append at the end
                     if (pos_ext > cnt_ext) begin
                        stat_in = lpa_pkg::ST_REDIRECT;
                     end
                     mem_cmd.wr_en   = 1'b1;
                     mem_cmd.wr_addr = cnt_idx;
                     mem_cmd.wr_data = req_ch.value;
                     count_in        = count_ff + lpa_pkg::CNT_W'(1);
                  end else begin
                     // open a gap: move entries up from the top
                     src_in   = last_idx;
                     dst_in   = cnt_idx;
                     stop_in  = pos_idx;
                     ins_in   = 1'b1;
                     count_in = count_ff + lpa_pkg::CNT_W'(1);
                     state_in = S_RD;
                  end
               end else if (count_ff == '0) begin
                  stat_in = lpa_pkg::ST_EMPTY;
               end else begin
                  unique case (req_ch.kind)
                     lpa_pkg::KIND_READ: begin
                        mem_cmd.rd_en = 1'b1;
                        rdf_in        = 1'b1;
                        if (pos_ext >= cnt_ext) begin
                           mem_cmd.rd_addr = last_idx;
                           stat_in         = lpa_pkg::ST_REDIRECT;
                        end else begin
                           mem_cmd.rd_addr = pos_idx;
                        end
                     end
                     lpa_pkg::KIND_REMOVE: begin
                        count_in = cnt_dec;
                        if (pos_ext >= cnt_ext) begin
                           stat_in = lpa_pkg::ST_REDIRECT;
                        end else if (pos_idx != last_idx) begin
                           // close the gap: move entries down from above
                           src_in   = pos_idx + lpa_pkg::IDX_W'(1);
                           dst_in   = pos_idx;
                           stop_in  = last_idx;
                           ins_in   = 1'b0;
                           state_in = S_RD;
                        end
                     end
                     lpa_pkg::KIND_ALTER: begin
                        if (pos_ext >= cnt_ext) begin
                           stat_in = lpa_pkg::ST_INVALID;
                        end else begin
                           mem_cmd.wr_en   = 1'b1;
                           mem_cmd.wr_addr = pos_idx;
                           mem_cmd.wr_data = req_ch.value;
                        end
                     end
                     default: begin
                        stat_in = lpa_pkg::ST_DONE;
                     end
                  endcase
               end
            end
         end
         S_RD: begin
            mem_cmd.rd_en   = 1'b1;
            mem_cmd.rd_addr = src_ff;
            state_in        = S_WR;
         end
         S_WR: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = dst_ff;
            mem_cmd.wr_data = mem_rd_data;
            if (src_ff == stop_ff) begin
               state_in = ins_ff ? S_FIN : S_OUT;
            end else begin
               state_in = S_RD;
               if (ins_ff) begin
                  src_in = src_ff - lpa_pkg::IDX_W'(1);
                  dst_in = dst_ff - lpa_pkg::IDX_W'(1);
               end else begin
                  src_in = src_ff + lpa_pkg::IDX_W'(1);
                  dst_in = dst_ff + lpa_pkg::IDX_W'(1);
               end
            end
         end
         S_FIN: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = stop_ff;
            mem_cmd.wr_data = val_ff;
            state_in        = S_OUT;
         end
         S_OUT: begin
            // hand the result over once the result register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rdf_ff ? mem_rd_data : '0;
               rsp_count_in = count_ff;
               rsp_stat_in  = stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and loop registers
   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      stop_ff      <= stop_in;
      val_ff       <= val_in;
      ins_ff       <= ins_in;
      rdf_ff       <= rdf_in;
      stat_ff      <= stat_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_value = rsp_value_ff;
   assign rsp_ch.item_count = rsp_count_ff;
   assign rsp_ch.status     = rsp_stat_ff;

`ifndef SYNTH
   // count moves only with an accepted request
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(count_ff))
      else $error("count changed without a request");

   // a taken request always leaves idle
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("sequencer stayed idle after a request");

   // a full report only when the list is at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_stat_ff == lpa_pkg::ST_FULL))
         |-> (rsp_count_ff == lpa_pkg::CNT_W'(lpa_pkg::CAPACITY)))
      else $error("full status with list not at capacity");

   // count never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (count_ff <= lpa_pkg::CNT_W'(lpa_pkg::CAPACITY)))
      else $error("count beyond capacity");
`endif

endmodule

FILE: verif/positional_array_list_checker.sv
module positional_array_list_checker (
   input  logic        clock,
   input  logic        reset,
   lpa_req_if          req_ch,
   lpa_rsp_if          rsp_ch,
   output int unsigned mismatch_count,
   output int unsigned pending_count
);

   typedef struct packed {
      logic signed [lpa_pkg::VAL_W-1:0] read_value;
      logic [lpa_pkg::CNT_W-1:0]        item_count;
      logic [lpa_pkg::STAT_W-1:0]       status;
   } list_outcome_type;

   // Shadow of the list contents and its length
   logic signed [lpa_pkg::VAL_W-1:0] shadow_words [lpa_pkg::CAPACITY];
   int                               shadow_len;
   list_outcome_type                 expected_outcomes [$];
   int unsigned                      fault_total;

   // Apply one request to the shadow list and return the response it should give
   function automatic list_outcome_type apply_list_op(
      input logic [lpa_pkg::KIND_W-1:0]        op,
      input logic [lpa_pkg::POS_W-1:0]         pos,
      input logic signed [lpa_pkg::VAL_W-1:0] word);
      list_outcome_type res;
      int               idx;
      int               at;
      res        = '0;
      res.status = lpa_pkg::ST_DONE;
      at         = int'(pos);
      if (op == lpa_pkg::KIND_INSERT) begin
         if (shadow_len >= lpa_pkg::CAPACITY) begin
            res.status = lpa_pkg::ST_FULL;
         end else if (at > lpa_pkg::CAPACITY - 1) begin
            res.status = lpa_pkg::ST_INVALID;
         end else if (at >= shadow_len) begin
            // append; a gap past the end is flagged as redirected
            if (at > shadow_len) res.status = lpa_pkg::ST_REDIRECT;
            shadow_words[shadow_len] = word;
            shadow_len++;
         end else begin
            for (idx = shadow_len; idx > at; idx--) shadow_words[idx] = shadow_words[idx-1];
            shadow_words[at] = word;
            shadow_len++;
         end
      end else if (shadow_len == 0) begin
         res.status = lpa_pkg::ST_EMPTY;
      end else if (op == lpa_pkg::KIND_READ) begin
         if (at >= shadow_len) begin
            at         = shadow_len - 1;
            res.status = lpa_pkg::ST_REDIRECT;
         end
         res.read_value = shadow_words[at];
      end else if (op == lpa_pkg::KIND_REMOVE) begin
         // past the end drops the last entry
         if (at >= shadow_len) begin
            res.status = lpa_pkg::ST_REDIRECT;
         end else begin
            for (idx = at; idx + 1 < shadow_len; idx++) shadow_words[idx] = shadow_words[idx+1];
         end
         shadow_len--;
      end else begin
         if (at >= shadow_len) res.status = lpa_pkg::ST_INVALID;
         else shadow_words[at] = word;
      end
      res.item_count = shadow_len[lpa_pkg::CNT_W-1:0];
      return res;
   endfunction

   initial begin
      shadow_len  = 0;
      fault_total = 0;
   end

   always @(posedge clock) begin
      list_outcome_type want;
      list_outcome_type got;
      if (reset) begin
         shadow_len = 0;
         expected_outcomes.delete();
      end else begin
         // accepted request: predict its response
         if (req_ch.valid && req_ch.ready) begin
            expected_outcomes.push_back(apply_list_op(req_ch.kind, req_ch.position,
                                                      req_ch.value));
         end
         // accepted response: compare with the oldest prediction
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.read_value = rsp_ch.read_value;
            got.item_count = rsp_ch.item_count;
            got.status     = rsp_ch.status;
            if (expected_outcomes.size() == 0) begin
               fault_total++;
               if (fault_total <= 10)
                  $display({"%0t: response with no request pending:",
                            " value %0d count %0d status %0d"},
                           $realtime, got.read_value, got.item_count, got.status);
            end else begin
               want = expected_outcomes.pop_front();
               if (got.read_value !== want.read_value || got.item_count !== want.item_count ||
                   got.status !== want.status) begin
                  fault_total++;
                  if (fault_total <= 10)
                     $display({"%0t: mismatch: expected value %0d count %0d status %0d,",
                               " got value %0d count %0d status %0d"},
                              $realtime, want.read_value, want.item_count, want.status,
                              got.read_value, got.item_count, got.status);
               end
            end
         end
      end
      pending_count  <= expected_outcomes.size();
      mismatch_count <= fault_total;
   end

endmodule

FILE: verif/positional_array_list_tb.sv
module positional_array_list_tb;

   localparam int RANDOM_ITEMS = 1770;
   localparam int TAIL_ITEMS   = 200;

   logic        clock;
   logic        reset;
   logic        quiet_tail;
   logic        hold_off_request;
   int unsigned mismatch_count;
   int unsigned pending_count;

   lpa_req_if req_ch ();
   lpa_rsp_if rsp_ch ();

   positional_array_list u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   positional_array_list_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      #8000000;
      $display("*** FAILED ***");
      $finish;
   end

   // Word picker: extremes show up often, the rest is uniform
   function automatic logic signed [lpa_pkg::VAL_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -1;
         default: return $signed($urandom());
      endcase
   endfunction

   // Offer one request, with an occasional idle burst ahead of it
   task automatic push_request(input logic [lpa_pkg::KIND_W-1:0]        op,
                               input logic [lpa_pkg::POS_W-1:0]         pos,
                               input logic signed [lpa_pkg::VAL_W-1:0] word);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.kind     <= op;
      req_ch.position <= pos;
      req_ch.value    <= word;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Response side: random stalls, one long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (quiet_tail) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      int unsigned                  n;
      int unsigned                  insert_weight;
      int unsigned                  roll;
      logic [lpa_pkg::KIND_W-1:0]   op;
      logic [lpa_pkg::POS_W-1:0]    pos;
      quiet_tail       = 1'b0;
      hold_off_request = 1'b0;
      insert_weight    = 50;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.kind     <= lpa_pkg::KIND_INSERT;
      req_ch.position <= '0;
      req_ch.value    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list refuses read, remove and alter
      push_request(lpa_pkg::KIND_READ,   4'd0, 32'sd0);
      push_request(lpa_pkg::KIND_REMOVE, 4'd15, 32'sd0);
      push_request(lpa_pkg::KIND_ALTER,  4'd0, 32'sd5);
      // append, append past the end, append at count, insert at the head
      push_request(lpa_pkg::KIND_INSERT, 4'd0, 32'sh7FFF_FFFF);
      push_request(lpa_pkg::KIND_INSERT, 4'd9, 32'sd1);
      push_request(lpa_pkg::KIND_INSERT, 4'd2, -1);
      push_request(lpa_pkg::KIND_INSERT, 4'd0, 32'sh8000_0000);
      // read in range and past the end, alter in range and past the end
      push_request(lpa_pkg::KIND_READ,   4'd0, 32'sd0);
      push_request(lpa_pkg::KIND_READ,   4'd15, 32'sd0);
      push_request(lpa_pkg::KIND_ALTER,  4'd2, 32'sd0);
      push_request(lpa_pkg::KIND_ALTER,  4'd14, 32'sd7);
      // fill up, then insert on a full list
      repeat (12) push_request(lpa_pkg::KIND_INSERT,
                               lpa_pkg::POS_W'($urandom_range(0, 15)), pick_word());
      push_request(lpa_pkg::KIND_INSERT, 4'd3, 32'sd9);
      push_request(lpa_pkg::KIND_READ,   4'd15, 32'sd0);
      push_request(lpa_pkg::KIND_ALTER,  4'd15, 32'sh5A5A_A5A5);
      // remove the top entry, then past the end, then from the head
      push_request(lpa_pkg::KIND_REMOVE, 4'd15, 32'sd0);
      push_request(lpa_pkg::KIND_REMOVE, 4'd15, 32'sd0);
      push_request(lpa_pkg::KIND_REMOVE, 4'd0, 32'sd0);

      // random traffic in phases that lean toward filling or draining the list
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) begin
            case ($urandom_range(0, 2))
               0:       insert_weight = 15;
               1:       insert_weight = 45;
               default: insert_weight = 85;
            endcase
         end
         if (n == 600) hold_off_request = 1'b1;
         if (n == RANDOM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < insert_weight) op = lpa_pkg::KIND_INSERT;
         else begin
            case ($urandom_range(0, 2))
               0:       op = lpa_pkg::KIND_READ;
               1:       op = lpa_pkg::KIND_REMOVE;
               default: op = lpa_pkg::KIND_ALTER;
            endcase
         end
         if ($urandom_range(0, 3) == 0) pos = lpa_pkg::POS_W'($urandom_range(0, 3));
         else pos = lpa_pkg::POS_W'($urandom_range(0, 15));
         push_request(op, pos, pick_word());
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);

      // drain, then allow for the longest shift
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
